/* rtl/qn_pkg.sv */
// ----------------------------------------------------------------------------
// qn_pkg
// Item types, control group and fixed widths for the quaternion normalizer.
// ----------------------------------------------------------------------------
package qn_pkg;

	localparam int COMP_W = 16;
	localparam int LANES  = 4;
	localparam int SQ_W   = 2 * COMP_W - 1;	// square of a magnitude up to 2^15
	localparam int SUM_W  = 2 * COMP_W + 1;	// sum of four squares

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_x;
		logic signed [COMP_W-1:0] comp_y;
		logic signed [COMP_W-1:0] comp_z;
		logic signed [COMP_W-1:0] comp_w;
	} quat_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] unit_x;
		logic signed [COMP_W-1:0] unit_y;
		logic signed [COMP_W-1:0] unit_z;
		logic signed [COMP_W-1:0] unit_w;
		logic                     degenerate;
	} unit_t;

	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [LANES-1:0] neg;
	} ctl_t;

endpackage

/* rtl/quaternion_normalizer.sv */
// ----------------------------------------------------------------------------
// quaternion_normalizer
// Scales a Q2.14 quaternion to unit length, rounded to nearest, Q2.14 out.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  input   | quat_valid, quat_stall | quat  (comp_x..comp_w)
//  output  | unit_valid, unit_stall | unit  (unit_x..unit_w, degenerate)
//
//  One item per cycle unless the output stalls; the pipeline has three front stages
//  (magnitude, square, sum), one search stage per result bit, one output stage.
//  Reset clears only the control bits. A stall on the output freezes the whole
//  pipeline and is passed straight back as quat_stall.
// ----------------------------------------------------------------------------
module quaternion_normalizer
	import qn_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  quat_valid,
	output logic  quat_stall,
	input  quat_t quat,
	output logic  unit_valid,
	input  logic  unit_stall,
	output unit_t unit
);

	localparam int AW = 2 * COMP_W + 2 * FRAC_BITS + 5;
	localparam int NS = FRAC_BITS + 2;
	localparam longint OUT_LIM = (FRAC_BITS < COMP_W - 1) ? (64'd1 << FRAC_BITS)
	                                                      : ((64'd1 << (COMP_W - 1)) - 1);

	logic               adv;
	ctl_t               c_p [NS];
	logic [SUM_W-1:0]   s_p [NS];
	logic [AW-1:0]      a_p [NS][LANES];
	logic [AW-1:0]      b_p [NS][LANES];
	logic [AW-1:0]      r_p [NS][LANES];
	logic [FRAC_BITS:0] q_p [NS][LANES];

	assign adv        = !(unit_valid && unit_stall);
	assign quat_stall = !adv;

	qn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .adv, .quat_valid, .quat,
		.ctl_s3(c_p[0]), .sum_s3(s_p[0]),
		.acc_a_s3(a_p[0]), .acc_b_s3(b_p[0]), .rhs_s3(r_p[0])
	);

	assign q_p[0] = '{default: '0};

	for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_step
		qn_step #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - g)) u_step (
			.clk, .arst_n, .adv,
			.ctl_i(c_p[g]), .sum_i(s_p[g]), .a_i(a_p[g]), .b_i(b_p[g]),
			.rhs_i(r_p[g]), .q_i(q_p[g]),
			.ctl_sn(c_p[g+1]), .sum_sn(s_p[g+1]), .a_sn(a_p[g+1]), .b_sn(b_p[g+1]),
			.rhs_sn(r_p[g+1]), .q_sn(q_p[g+1])
		);
	end

	qn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .adv, .ctl_i(c_p[NS-1]), .q_i(q_p[NS-1]),
		.unit_valid, .unit
	);

	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit.degenerate |->
			unit.unit_x == '0 && unit.unit_y == '0 && unit.unit_z == '0 &&
			unit.unit_w == COMP_W'(OUT_LIM))
		else $error("degenerate item is not the identity");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> $signed(unit.unit_x) <= $signed(COMP_W'(OUT_LIM)) &&
			$signed(unit.unit_x) >= -$signed(COMP_W'(OUT_LIM)))
		else $error("unit_x beyond 1.0");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> $signed(unit.unit_w) <= $signed(COMP_W'(OUT_LIM)) &&
			$signed(unit.unit_w) >= -$signed(COMP_W'(OUT_LIM)))
		else $error("unit_w beyond 1.0");

endmodule

/* rtl/qn_front.sv */
// ----------------------------------------------------------------------------
// qn_front
// Magnitudes, squares and their sum; seeds the per-lane search accumulators.
// ----------------------------------------------------------------------------
module qn_front
	import qn_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 quat_valid,
	input  quat_t                quat,
	output ctl_t                 ctl_s3,
	output logic [SUM_W-1:0]     sum_s3,
	output logic [2*COMP_W+2*FRAC_BITS+4:0] acc_a_s3 [LANES],
	output logic [2*COMP_W+2*FRAC_BITS+4:0] acc_b_s3 [LANES],
	output logic [2*COMP_W+2*FRAC_BITS+4:0] rhs_s3 [LANES]
);

	localparam int AW = 2 * COMP_W + 2 * FRAC_BITS + 5;

	logic [COMP_W-1:0] comp  [LANES];
	logic [COMP_W-1:0] mag   [LANES];
	logic [LANES-1:0]  neg;
	ctl_t              ctl_s1, ctl_s2;
	logic [COMP_W-1:0] mag_s1 [LANES];
	logic [SQ_W-1:0]   sq_s2  [LANES];
	logic [SUM_W-1:0]  sum;

	assign comp[0] = quat.comp_x;
	assign comp[1] = quat.comp_y;
	assign comp[2] = quat.comp_z;
	assign comp[3] = quat.comp_w;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			neg[k] = comp[k][COMP_W-1];
			// most negative value maps to 2^15 as an unsigned magnitude
			mag[k] = neg[k] ? COMP_W'(~comp[k] + 1'b1) : comp[k];
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < LANES; k++)
			sum = sum + SUM_W'(sq_s2[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= quat_valid;
			ctl_s1.zero  <= (quat == '0);
			ctl_s1.neg   <= neg;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				mag_s1[k]   <= mag[k];
				sq_s2[k]    <= SQ_W'(mag_s1[k]) * SQ_W'(mag_s1[k]);
				rhs_s3[k]   <= AW'(sq_s2[k]) << (2 * FRAC_BITS + 2);
				acc_a_s3[k] <= AW'(sum);
				acc_b_s3[k] <= AW'(~AW'(sum) + 1'b1);
			end
			sum_s3 <= sum;
		end
	end

endmodule

/* rtl/qn_step.sv */
// ----------------------------------------------------------------------------
// qn_step
// One bit of the rounded-quotient search, all four lanes.
// Keeps A = t^2*S and B = t*S for t = 2q-1 and tries t + 2^(BIT+1).
// ----------------------------------------------------------------------------
module qn_step
	import qn_pkg::*;
#(
	parameter int FRAC_BITS = 14,
	parameter int BIT       = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ctl_t                 ctl_i,
	input  logic [SUM_W-1:0]     sum_i,
	input  logic [2*COMP_W+2*FRAC_BITS+4:0] a_i   [LANES],
	input  logic [2*COMP_W+2*FRAC_BITS+4:0] b_i   [LANES],
	input  logic [2*COMP_W+2*FRAC_BITS+4:0] rhs_i [LANES],
	input  logic [FRAC_BITS:0]   q_i   [LANES],
	output ctl_t                 ctl_sn,
	output logic [SUM_W-1:0]     sum_sn,
	output logic [2*COMP_W+2*FRAC_BITS+4:0] a_sn   [LANES],
	output logic [2*COMP_W+2*FRAC_BITS+4:0] b_sn   [LANES],
	output logic [2*COMP_W+2*FRAC_BITS+4:0] rhs_sn [LANES],
	output logic [FRAC_BITS:0]   q_sn   [LANES]
);

	localparam int AW = 2 * COMP_W + 2 * FRAC_BITS + 5;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic [AW-1:0]    a_try [LANES];
	logic [LANES-1:0] take;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			a_try[k] = a_i[k] + (b_i[k] << (BIT + 2)) + (AW'(sum_i) << (2 * BIT + 2));
			// once q reached 1.0 no lower bit may be added
			take[k]  = (q_i[k] != ONE) && (a_try[k] <= rhs_i[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_sn <= '0;
		else if (adv)
			ctl_sn <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_sn <= sum_i;
			for (int k = 0; k < LANES; k++) begin
				rhs_sn[k] <= rhs_i[k];
				a_sn[k]   <= take[k] ? a_try[k] : a_i[k];
				b_sn[k]   <= take[k] ? (b_i[k] + (AW'(sum_i) << (BIT + 1))) : b_i[k];
				q_sn[k]   <= take[k] ? (q_i[k] | ((FRAC_BITS+1)'(1) << BIT)) : q_i[k];
			end
		end
	end

endmodule

/* rtl/qn_back.sv */
// ----------------------------------------------------------------------------
// qn_back
// Saturation, sign and the identity result; output register.
// ----------------------------------------------------------------------------
module qn_back
	import qn_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  ctl_t               ctl_i,
	input  logic [FRAC_BITS:0] q_i [LANES],
	output logic               unit_valid,
	output unit_t              unit
);

	localparam longint LIM = (FRAC_BITS < COMP_W - 1) ? (64'd1 << FRAC_BITS)
	                                                  : ((64'd1 << (COMP_W - 1)) - 1);
	localparam logic [FRAC_BITS:0] LIM_Q = (FRAC_BITS+1)'(LIM);

	logic [COMP_W-1:0] res [LANES];
	logic [FRAC_BITS:0] sat;
	unit_t              nxt;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			sat    = (q_i[k] > LIM_Q) ? LIM_Q : q_i[k];
			res[k] = ctl_i.neg[k] ? COMP_W'(~COMP_W'(sat) + 1'b1) : COMP_W'(sat);
		end
		if (ctl_i.zero) begin
			nxt.unit_x     = '0;
			nxt.unit_y     = '0;
			nxt.unit_z     = '0;
			nxt.unit_w     = COMP_W'(LIM);
			nxt.degenerate = 1'b1;
		end else begin
			nxt.unit_x     = res[0];
			nxt.unit_y     = res[1];
			nxt.unit_z     = res[2];
			nxt.unit_w     = res[3];
			nxt.degenerate = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unit_valid <= 1'b0;
		else if (adv)
			unit_valid <= ctl_i.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			unit <= nxt;
	end

endmodule

/* test/quaternion_normalizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_normalizer_tb
// Sends directed and random quaternions through the normalizer with random
// input gaps and output stalls. Each result is checked field by field against
// an exact integer computation of the rounded unit quaternion.
// ----------------------------------------------------------------------------
module quaternion_normalizer_tb;
	import qn_pkg::*;

	localparam int ONE = 1 << 14;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  quat_valid = 1'b0;
	logic  quat_stall;
	quat_t quat = '0;
	logic  unit_valid;
	logic  unit_stall = 1'b0;
	unit_t unit;

	unit_t expected_units[$];
	int    errors = 0;
	int    burst_left = 0;
	int    hold_left = 0;
	bit    gaps_on = 1'b1;
	bit    stalls_on = 1'b1;

	quaternion_normalizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat_valid(quat_valid),
		.quat_stall(quat_stall),
		.quat      (quat),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit      (unit)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// largest q <= 1.0 with (2q-1)^2 * sum <= (2 * c * 2^14)^2, i.e. round half up
	function automatic logic [15:0] scale_mag(longint unsigned c, longint unsigned mags[4]);
		bit [127:0] rhs, lhs, t, cand;
		longint unsigned q;
		q = 0;
		rhs = (c << 15) * (c << 15);
		for (int b = 14; b >= 0; b--) begin
			cand = q | (64'd1 << b);
			if (cand > ONE)
				continue;
			t = 2 * cand - 1;
			lhs = 0;
			for (int k = 0; k < 4; k++)
				lhs += (t * mags[k]) * (t * mags[k]);
			if (lhs <= rhs)
				q = 64'(cand);
		end
		return q[15:0];
	endfunction

	function automatic unit_t normalize(quat_t qin);
		unit_t           r;
		longint          v[4];
		longint unsigned mags[4];
		logic [15:0]     res[4];
		v = '{qin.comp_x, qin.comp_y, qin.comp_z, qin.comp_w};
		for (int k = 0; k < 4; k++)
			mags[k] = v[k] < 0 ? -v[k] : v[k];
		if (mags[0] + mags[1] + mags[2] + mags[3] == 0) begin
			r = '0;
			r.unit_w = 16'(ONE);
			r.degenerate = 1'b1;
			return r;
		end
		for (int k = 0; k < 4; k++) begin
			res[k] = scale_mag(mags[k], mags);
			if (v[k] < 0)
				res[k] = -res[k];
		end
		r.unit_x = res[0];
		r.unit_y = res[1];
		r.unit_z = res[2];
		r.unit_w = res[3];
		r.degenerate = 1'b0;
		return r;
	endfunction

	// receiver stall pattern, with an optional long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				unit_stall <= 1'b1;
				hold_left--;
			end else
				unit_stall <= stalls_on && ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && unit_valid && !unit_stall) begin
			if (expected_units.size() == 0) begin
				$error("unexpected item: %p", unit);
				errors++;
			end else begin
				unit_t e;
				e = expected_units.pop_front();
				if (unit.unit_x !== e.unit_x) begin
					$error("unit_x: expected %0d, got %0d", e.unit_x, unit.unit_x);
					errors++;
				end
				if (unit.unit_y !== e.unit_y) begin
					$error("unit_y: expected %0d, got %0d", e.unit_y, unit.unit_y);
					errors++;
				end
				if (unit.unit_z !== e.unit_z) begin
					$error("unit_z: expected %0d, got %0d", e.unit_z, unit.unit_z);
					errors++;
				end
				if (unit.unit_w !== e.unit_w) begin
					$error("unit_w: expected %0d, got %0d", e.unit_w, unit.unit_w);
					errors++;
				end
				if (unit.degenerate !== e.degenerate) begin
					$error("degenerate: expected %0b, got %0b", e.degenerate,
						unit.degenerate);
					errors++;
				end
			end
		end
	end

	// called and returns at a rising edge
	task automatic send_quat(quat_t qin);
		quat <= qin;
		quat_valid <= 1'b1;
		do
			@(posedge clk);
		while (quat_stall);
		expected_units.insert(expected_units.size(), normalize(qin));
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 20);
			if (gaps_on) begin
				quat_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	function automatic quat_t make_quat(int x, int y, int z, int w);
		quat_t r;
		r.comp_x = 16'(x);
		r.comp_y = 16'(y);
		r.comp_z = 16'(z);
		r.comp_w = 16'(w);
		return r;
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 15) - 8);
			1: return 16'($urandom_range(0, 600) - 300);
			2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			3: return 16'h0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_quat(make_quat(0, 0, 0, 0));
		send_quat(make_quat(32767, 32767, 32767, 32767));
		send_quat(make_quat(-32768, -32768, -32768, -32768));
		send_quat(make_quat(-32768, 0, 0, 0));
		send_quat(make_quat(0, 32767, 0, 0));
		send_quat(make_quat(0, 0, -1, 0));
		send_quat(make_quat(0, 0, 0, 1));
		send_quat(make_quat(1, 1, 1, 1));
		send_quat(make_quat(-1, 1, -1, 1));
		send_quat(make_quat(16384, 0, 0, 0));
		send_quat(make_quat(1, 0, 0, -32768));
		send_quat(make_quat(-1, 0, 0, 32767));
		send_quat(make_quat(3, 4, 0, 0));
		send_quat(make_quat(-32768, 32767, -32768, 32767));
		send_quat(make_quat(0, 0, 0, 0));
		send_quat(make_quat(1, 2, 2, 4));
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 300 == 0) begin
				gaps_on = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 3) == 0)
				send_quat(make_quat($urandom, $urandom, $urandom, $urandom));
			else
				send_quat(make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_left = 80;
		for (int i = 0; i < 60; i++)
			send_quat(make_quat($urandom, $urandom, $urandom, $urandom));
		gaps_on = 1'b1;
	endtask

	initial begin
		test_reset();
		test_directed();
		test_random(700);
		test_backpressure();
		test_random(650);
		quat_valid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/qn_pkg.sv
rtl/qn_front.sv
rtl/qn_step.sv
rtl/qn_back.sv
rtl/quaternion_normalizer.sv
test/quaternion_normalizer_tb.sv
